FILE: design/slice_run_length_decoder_top_defines.svh
// Assertion macros used by the slice run-length decoder top module.
`ifndef SLICE_RUN_LENGTH_DECODER_TOP_DEFINES_SVH
`define SLICE_RUN_LENGTH_DECODER_TOP_DEFINES_SVH

`ifndef SYNTHESIS
// Checked property, switched off while reset is high.
`define SLRD_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);
// Checked property that also holds across reset.
`define SLRD_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) (prop)) else $error(msg);
`else
`define SLRD_ASSERT(label, prop, msg)
`define SLRD_ASSERT_ALWAYS(label, prop, msg)
`endif

`endif

FILE: design/slrd_pkg.sv
// Types and constants of the slice run-length decoder.
package slrd_pkg;

   // Default bound on the slice width and height.
   localparam int DEFAULT_MAX_SLICE_SIDE = 4096;

   // Header layout: magic, width, height, id width, then one pad byte.
   localparam int MAGIC_LEN      = 4;
   localparam int WIDTH_END      = 8;
   localparam int HEIGHT_END     = 12;
   localparam int HDR_FIELDS_LEN = 16;

   // Magic bytes "FFSL", first byte in the lowest lane.
   localparam logic [3:0][7:0] MAGIC = {8'h4C, 8'h53, 8'h46, 8'h46};

   // Allowed id widths in bytes.
   localparam logic [7:0] ID_WIDTH_NARROW = 8'd1;
   localparam logic [7:0] ID_WIDTH_WIDE   = 8'd2;

   typedef enum logic [1:0] {
      KIND_RUN    = 2'd0,
      KIND_HEADER = 2'd1,
      KIND_ERROR  = 2'd2
   } kind_type;

   typedef enum logic [2:0] {
      ERR_NONE      = 3'd0,
      ERR_BAD_MAGIC = 3'd1,
      ERR_TOO_LARGE = 3'd2,
      ERR_ID_WIDTH  = 3'd3,
      ERR_OVERFLOW  = 3'd4,
      ERR_TRUNCATED = 3'd5
   } err_type;

endpackage

FILE: design/slice_run_length_decoder_top.sv
// Slice run-length decoder: header parser and run decoder, one byte per word.
//
// Usage: the input channel (req_*) carries one byte of a slice file per word,
// with req_final_byte marking the last byte available. The result channel
// (rsp_*) carries at most one word per input byte: a header-accepted word
// after the pad byte, a run word after each count byte, or an error word.
// Pipeline: a byte is held in the input register and its result in the result register.
// Throughput: one byte per cycle unless rsp_stall holds a waiting result; the decode
// of a byte is a single pass of logic between the input register and the result
// register, and the only multiplier in that pass is the width times height one.
// Reset: synchronous, clears both pipeline registers and all parse state;
// the first byte after reset must start a header.
// Stall: when rsp_stall holds a waiting result, the byte in the input
// register waits too and req_stall rises; bytes that give no result still
// pass. Up to two words sit in the block while the receiver stalls.
`include "slice_run_length_decoder_top_defines.svh"

module slice_run_length_decoder_top
   import slrd_pkg::*;
#(
   parameter int MAX_SLICE_SIDE = DEFAULT_MAX_SLICE_SIDE,
   localparam int SIDE_W = $clog2(MAX_SLICE_SIDE + 1),
   localparam longint MAX_CELLS = longint'(MAX_SLICE_SIDE) * longint'(MAX_SLICE_SIDE),
   localparam int CELL_W = $clog2(MAX_CELLS + 1)
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic [7:0]        req_stream_byte,
   input  logic              req_final_byte,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [1:0]        rsp_kind,
   output logic [15:0]       rsp_material_id,
   output logic [7:0]        rsp_run_length,
   output logic [CELL_W-1:0] rsp_run_start,
   output logic [SIDE_W-1:0] rsp_slice_width,
   output logic [SIDE_W-1:0] rsp_slice_height,
   output logic              rsp_slice_done,
   output logic [15:0]       rsp_max_material,
   output logic [2:0]        rsp_error_code
);

   typedef enum logic [1:0] {
      PH_HEADER,
      PH_RUNS,
      PH_DRAIN
   } phase_type;

   // Input register.
   logic       in_vld_ff;
   logic [7:0] in_byte_ff;
   logic       in_final_ff;

   // Parse state.
   phase_type   phase_ff, phase_in;
   logic [4:0]  hdr_cnt_ff, hdr_cnt_in;
   logic [31:0] width_ff, width_in;
   logic [31:0] height_ff, height_in;
   logic        wide_ff, wide_in;
   logic        idbad_ff, idbad_in;
   logic [CELL_W-1:0] cells_ff, cells_in;
   logic [CELL_W-1:0] pos_ff, pos_in;
   logic [15:0] pend_ff, pend_in;
   logic [1:0]  idph_ff, idph_in;
   logic [15:0] largest_ff, largest_in;

   // Result register.
   logic              rsp_vld_ff;
   kind_type          rsp_kind_ff;
   logic [15:0]       rsp_id_ff;
   logic [7:0]        rsp_len_ff;
   logic [CELL_W-1:0] rsp_start_ff;
   logic [SIDE_W-1:0] rsp_width_ff;
   logic [SIDE_W-1:0] rsp_height_ff;
   logic              rsp_done_ff;
   logic [15:0]       rsp_max_ff;
   err_type           rsp_err_ff;

   // Result of the byte in the input register.
   logic              res_vld;
   kind_type          res_kind;
   logic [15:0]       res_id;
   logic [CELL_W-1:0] res_start;
   logic              res_done;
   err_type           res_err;
   logic              err_hit;
   err_type           err_code;
   logic              pad_byte;

   logic              advance;
   logic [2*SIDE_W-1:0] cell_product;
   logic [31:0]       pos_sum;
   logic [31:0]       left_diff;
   logic              run_fits;
   logic              run_ends;

   // The byte moves on when its result has room or it gives no result.
   assign advance   = in_vld_ff && (!res_vld || !rsp_vld_ff || !rsp_stall);
   assign req_stall = in_vld_ff && !advance;

   // Cell count of the slice, from the bounded width and height.
   assign cell_product = (2*SIDE_W)'(width_ff[SIDE_W-1:0]) *
                         (2*SIDE_W)'(height_ff[SIDE_W-1:0]);

   // Run arithmetic on the count byte.
   assign run_fits  = 32'(in_byte_ff) <= 32'(cells_ff);
   assign run_ends  = 32'(in_byte_ff) == 32'(cells_ff);
   assign pos_sum   = 32'(pos_ff) + 32'(in_byte_ff);
   assign left_diff = 32'(cells_ff) - 32'(in_byte_ff);

   // Decode of one byte.
   always_comb begin
      phase_in   = phase_ff;
      hdr_cnt_in = hdr_cnt_ff;
      width_in   = width_ff;
      height_in  = height_ff;
      wide_in    = wide_ff;
      idbad_in   = idbad_ff;
      cells_in   = cells_ff;
      pos_in     = pos_ff;
      pend_in    = pend_ff;
      idph_in    = idph_ff;
      largest_in = largest_ff;
      res_vld    = 1'b0;
      res_kind   = KIND_RUN;
      res_id     = '0;
      res_start  = '0;
      res_done   = 1'b0;
      res_err    = ERR_NONE;
      err_hit    = 1'b0;
      err_code   = ERR_NONE;
      pad_byte   = 1'b0;

      unique case (phase_ff)
         PH_DRAIN: begin
            // Skip bytes until the end of the stream.
            if (in_final_ff) begin
               phase_in = PH_HEADER;
            end
         end
         PH_RUNS: begin
            case (idph_ff)
               2'd0: begin
                  pend_in = {8'd0, in_byte_ff};
                  idph_in = wide_ff ? 2'd1 : 2'd2;
               end
               2'd1: begin
                  pend_in[15:8] = in_byte_ff;
                  idph_in       = 2'd2;
               end
               default: begin
                  // Count byte: place the run or flag an overflow.
                  idph_in = 2'd0;
                  if (!run_fits) begin
                     err_hit  = 1'b1;
                     err_code = ERR_OVERFLOW;
                  end else begin
                     pos_in    = pos_sum[CELL_W-1:0];
                     cells_in  = left_diff[CELL_W-1:0];
                     if (in_byte_ff != 8'd0 && pend_ff > largest_ff) begin
                        largest_in = pend_ff;
                     end
                     res_vld   = 1'b1;
                     res_kind  = KIND_RUN;
                     res_id    = pend_ff;
                     res_start = pos_ff;
                     res_done  = run_ends;
                     if (run_ends) begin
                        phase_in   = in_final_ff ? PH_HEADER : PH_DRAIN;
                        hdr_cnt_in = '0;
                     end else if (in_final_ff) begin
                        res_err    = ERR_TRUNCATED;
                        phase_in   = PH_HEADER;
                        hdr_cnt_in = '0;
                     end
                  end
               end
            endcase
            if (idph_ff != 2'd2 && idph_ff != 2'd3 && in_final_ff) begin
               err_hit  = 1'b1;
               err_code = ERR_TRUNCATED;
            end
         end
         default: begin
            // A new file clears everything it owns.
            if (hdr_cnt_ff == '0) begin
               width_in   = '0;
               height_in  = '0;
               wide_in    = 1'b0;
               idbad_in   = 1'b0;
               cells_in   = '0;
               pos_in     = '0;
               pend_in    = '0;
               idph_in    = '0;
               largest_in = '0;
            end
            if (hdr_cnt_ff < 5'(MAGIC_LEN)) begin
               if (in_byte_ff != MAGIC[hdr_cnt_ff[1:0]]) begin
                  err_hit  = 1'b1;
                  err_code = ERR_BAD_MAGIC;
               end
            end else if (hdr_cnt_ff < 5'(WIDTH_END)) begin
               width_in[{hdr_cnt_ff[1:0], 3'b000} +: 8] = in_byte_ff;
            end else if (hdr_cnt_ff < 5'(HEIGHT_END)) begin
               height_in[{hdr_cnt_ff[1:0], 3'b000} +: 8] = in_byte_ff;
            end else if (hdr_cnt_ff < 5'(HDR_FIELDS_LEN)) begin
               // Id width: only 1 or 2 in the low byte, upper bytes zero.
               if (hdr_cnt_ff == 5'(HEIGHT_END)) begin
                  wide_in = (in_byte_ff == ID_WIDTH_WIDE);
                  if (in_byte_ff != ID_WIDTH_NARROW && in_byte_ff != ID_WIDTH_WIDE) begin
                     idbad_in = 1'b1;
                  end
               end else if (in_byte_ff != 8'd0) begin
                  idbad_in = 1'b1;
               end
               if (hdr_cnt_ff == 5'(HDR_FIELDS_LEN - 1)) begin
                  if (width_ff > 32'(MAX_SLICE_SIDE) || height_ff > 32'(MAX_SLICE_SIDE)) begin
                     err_hit  = 1'b1;
                     err_code = ERR_TOO_LARGE;
                  end else if (idbad_in) begin
                     err_hit  = 1'b1;
                     err_code = ERR_ID_WIDTH;
                  end
               end
            end else begin
               // Pad byte: the header is complete.
               pad_byte   = 1'b1;
               cells_in   = cell_product[CELL_W-1:0];
               pos_in     = '0;
               idph_in    = '0;
               hdr_cnt_in = '0;
               res_vld    = 1'b1;
               res_kind   = KIND_HEADER;
               if (width_ff == '0 || height_ff == '0) begin
                  res_done = 1'b1;
                  phase_in = in_final_ff ? PH_HEADER : PH_DRAIN;
               end else if (in_final_ff) begin
                  res_err  = ERR_TRUNCATED;
                  phase_in = PH_HEADER;
               end else begin
                  phase_in = PH_RUNS;
               end
            end
            if (!pad_byte && !err_hit) begin
               hdr_cnt_in = hdr_cnt_ff + 5'd1;
               if (in_final_ff) begin
                  err_hit  = 1'b1;
                  err_code = ERR_TRUNCATED;
               end
            end
         end
      endcase

      // An error ends the file and gives an error-only word.
      if (err_hit) begin
         res_vld    = 1'b1;
         res_kind   = KIND_ERROR;
         res_id     = '0;
         res_start  = pos_in;
         res_done   = 1'b0;
         res_err    = err_code;
         phase_in   = in_final_ff ? PH_HEADER : PH_DRAIN;
         hdr_cnt_in = '0;
      end
   end

   // Input register.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
      end else if (req_valid && !req_stall) begin
         in_vld_ff <= 1'b1;
      end else if (advance) begin
         in_vld_ff <= 1'b0;
      end
      if (req_valid && !req_stall) begin
         in_byte_ff  <= req_stream_byte;
         in_final_ff <= req_final_byte;
      end
   end

   // Parse state, updated when the byte moves on.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_HEADER;
         hdr_cnt_ff <= '0;
         width_ff   <= '0;
         height_ff  <= '0;
         wide_ff    <= 1'b0;
         idbad_ff   <= 1'b0;
         cells_ff   <= '0;
         pos_ff     <= '0;
         pend_ff    <= '0;
         idph_ff    <= '0;
         largest_ff <= '0;
      end else if (advance) begin
         phase_ff   <= phase_in;
         hdr_cnt_ff <= hdr_cnt_in;
         width_ff   <= width_in;
         height_ff  <= height_in;
         wide_ff    <= wide_in;
         idbad_ff   <= idbad_in;
         cells_ff   <= cells_in;
         pos_ff     <= pos_in;
         pend_ff    <= pend_in;
         idph_ff    <= idph_in;
         largest_ff <= largest_in;
      end
   end

   // Result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else if (advance && res_vld) begin
         rsp_vld_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_vld_ff <= 1'b0;
      end
      if (advance && res_vld) begin
         rsp_kind_ff   <= res_kind;
         rsp_id_ff     <= res_id;
         rsp_len_ff    <= (res_kind == KIND_RUN) ? in_byte_ff : 8'd0;
         rsp_start_ff  <= res_start;
         rsp_width_ff  <= width_in[SIDE_W-1:0];
         rsp_height_ff <= height_in[SIDE_W-1:0];
         rsp_done_ff   <= res_done;
         rsp_max_ff    <= largest_in;
         rsp_err_ff    <= res_err;
      end
   end

   assign rsp_valid        = rsp_vld_ff;
   assign rsp_kind         = rsp_kind_ff;
   assign rsp_material_id  = rsp_id_ff;
   assign rsp_run_length   = rsp_len_ff;
   assign rsp_run_start    = rsp_start_ff;
   assign rsp_slice_width  = rsp_width_ff;
   assign rsp_slice_height = rsp_height_ff;
   assign rsp_slice_done   = rsp_done_ff;
   assign rsp_max_material = rsp_max_ff;
   assign rsp_error_code   = rsp_err_ff;

   // A run word only ever carries no error or a truncation.
   `SLRD_ASSERT(a_run_err, rsp_vld_ff && rsp_kind_ff == KIND_RUN |-> rsp_err_ff == ERR_NONE || rsp_err_ff == ERR_TRUNCATED, "run word with a content error")
   // An error-only word never closes the slice and carries no run.
   `SLRD_ASSERT(a_err_word, rsp_vld_ff && rsp_kind_ff == KIND_ERROR |-> !rsp_done_ff && rsp_len_ff == 8'd0 && rsp_err_ff != ERR_NONE, "malformed error word")
   // While runs are decoded the slice still has cells to cover.
   `SLRD_ASSERT(a_runs_cells, phase_ff == PH_RUNS |-> cells_ff != '0, "run phase with no cells left")
   // The header counter never runs past the pad byte.
   `SLRD_ASSERT(a_hdr_cnt, hdr_cnt_ff <= 5'(HDR_FIELDS_LEN), "header byte count out of range")
   // Reset empties both pipeline registers.
   `SLRD_ASSERT_ALWAYS(a_reset_empty, reset |=> !rsp_vld_ff && !in_vld_ff, "pipeline not empty after reset")

endmodule

FILE: tb/sv/tb_top.sv
// Self-checking testbench for the slice run-length decoder, with its own decode predictor.
module tb_top;
   import slrd_pkg::*;

   localparam int MAX_SIDE  = DEFAULT_MAX_SLICE_SIDE;
   localparam int SIDE_BITS = $clog2(MAX_SIDE + 1);
   localparam int CELL_BITS = $clog2(longint'(MAX_SIDE) * longint'(MAX_SIDE) + 1);

   // Header with its pad byte; an index past the end means no final byte in it.
   localparam int HDR_LEN    = HDR_FIELDS_LEN + 1;
   localparam int HDR_PAD    = HDR_FIELDS_LEN;
   localparam int HDR_NO_FIN = HDR_LEN;
   localparam int NO_CORRUPT = -1;

   // Where a run carries its final byte.
   localparam int FIN_ID_LOW  = 0;
   localparam int FIN_ID_HIGH = 1;
   localparam int FIN_COUNT   = 2;
   localparam int FIN_NONE    = 3;

   localparam int RANDOM_BYTES     = 500;
   localparam int MAX_RUNS_PER_FILE = 40;
   localparam int HOLD_CYCLES      = 300;
   localparam int MAX_REPORTS      = 10;
   localparam int DRAIN_LIMIT      = 200000;
   localparam int SETTLE_CYCLES    = 8;

   typedef enum {HDR_PARSE, RUN_PARSE, SKIP_TO_END} parse_state_type;

   typedef struct {
      kind_type             kind;
      logic [15:0]          material_id;
      logic [7:0]           run_length;
      logic [CELL_BITS-1:0] run_start;
      logic [SIDE_BITS-1:0] slice_width;
      logic [SIDE_BITS-1:0] slice_height;
      logic                 slice_done;
      logic [15:0]          max_material;
      err_type              error_code;
   } slice_word_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_stall;
   logic [7:0]           req_stream_byte = 8'h00;
   logic                 req_final_byte = 1'b0;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   logic [1:0]           rsp_kind;
   logic [15:0]          rsp_material_id;
   logic [7:0]           rsp_run_length;
   logic [CELL_BITS-1:0] rsp_run_start;
   logic [SIDE_BITS-1:0] rsp_slice_width;
   logic [SIDE_BITS-1:0] rsp_slice_height;
   logic                 rsp_slice_done;
   logic [15:0]          rsp_max_material;
   logic [2:0]           rsp_error_code;

   slice_word_type expected_words[$];
   int          error_total = 0;
   int          bytes_decoded = 0;
   int          send_idle_pct = 0;
   int          recv_idle_pct = 0;
   logic        holding = 1'b0;

   // Predictor state for the file being parsed.
   parse_state_type dec_state = HDR_PARSE;
   int unsigned  hdr_count;
   logic [31:0]  hdr_width, hdr_height;
   bit           ids_wide, id_width_bad;
   logic [31:0]  cells_remaining, next_cell;
   logic [15:0]  run_id, top_id;
   int           id_phase;

   slice_run_length_decoder_top dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_stream_byte  (req_stream_byte),
      .req_final_byte   (req_final_byte),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_kind         (rsp_kind),
      .rsp_material_id  (rsp_material_id),
      .rsp_run_length   (rsp_run_length),
      .rsp_run_start    (rsp_run_start),
      .rsp_slice_width  (rsp_slice_width),
      .rsp_slice_height (rsp_slice_height),
      .rsp_slice_done   (rsp_slice_done),
      .rsp_max_material (rsp_max_material),
      .rsp_error_code   (rsp_error_code)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // ---------------------------------------------------------------- predictor

   // Forget everything learned from the previous file.
   function automatic void clear_file();
      hdr_count       = 0;
      hdr_width       = '0;
      hdr_height      = '0;
      ids_wide        = 1'b0;
      id_width_bad    = 1'b0;
      cells_remaining = '0;
      next_cell       = '0;
      run_id          = '0;
      id_phase        = 0;
      top_id          = '0;
   endfunction

   // A file ends: either a new header follows at once or bytes are skipped up to a final one.
   function automatic void close_file(bit fin);
      dec_state = fin ? HDR_PARSE : SKIP_TO_END;
      hdr_count = 0;
   endfunction

   function automatic slice_word_type pack_word(kind_type k, logic [15:0] id, logic [7:0] len,
                                                logic [31:0] start, bit done, err_type err);
      slice_word_type w;
      w.kind         = k;
      w.material_id  = id;
      w.run_length   = len;
      w.run_start    = start[CELL_BITS-1:0];
      w.slice_width  = hdr_width[SIDE_BITS-1:0];
      w.slice_height = hdr_height[SIDE_BITS-1:0];
      w.slice_done   = done;
      w.max_material = top_id;
      w.error_code   = err;
      return w;
   endfunction

   function automatic slice_word_type abort_file(err_type err, bit fin);
      slice_word_type w;
      w = pack_word(KIND_ERROR, '0, '0, next_cell, 1'b0, err);
      close_file(fin);
      return w;
   endfunction

   // Advances the predictor by one byte; returns 1 when the byte yields a result word.
   function automatic bit decode_byte(input logic [7:0] b, input bit fin,
                                      output slice_word_type w);
      int unsigned n;
      logic [31:0] start;
      if (dec_state == SKIP_TO_END) begin
         if (fin) dec_state = HDR_PARSE;
         return 1'b0;
      end
      if (dec_state == HDR_PARSE) begin
         n = hdr_count;
         if (n == 0) clear_file();
         if (n < MAGIC_LEN) begin
            if (b !== MAGIC[n]) begin
               w = abort_file(ERR_BAD_MAGIC, fin);
               return 1'b1;
            end
         end else if (n < WIDTH_END) begin
            hdr_width |= 32'(b) << (8 * (n - MAGIC_LEN));
         end else if (n < HEIGHT_END) begin
            hdr_height |= 32'(b) << (8 * (n - WIDTH_END));
         end else if (n < HDR_FIELDS_LEN) begin
            // All four id-width bytes count, not just the first.
            if (n == HEIGHT_END) begin
               ids_wide = (b == ID_WIDTH_WIDE);
               if (b != ID_WIDTH_NARROW && b != ID_WIDTH_WIDE) id_width_bad = 1'b1;
            end else if (b != 8'h00) begin
               id_width_bad = 1'b1;
            end
            // Size errors win over a bad id width, and both win over truncation.
            if (n == HDR_FIELDS_LEN - 1) begin
               if (hdr_width > MAX_SIDE || hdr_height > MAX_SIDE) begin
                  w = abort_file(ERR_TOO_LARGE, fin);
                  return 1'b1;
               end
               if (id_width_bad) begin
                  w = abort_file(ERR_ID_WIDTH, fin);
                  return 1'b1;
               end
            end
         end else begin
            // Pad byte: the header is complete.
            cells_remaining = hdr_width * hdr_height;
            next_cell       = '0;
            id_phase        = 0;
            hdr_count       = 0;
            if (cells_remaining == 0) begin
               w = pack_word(KIND_HEADER, '0, '0, '0, 1'b1, ERR_NONE);
               close_file(fin);
            end else if (fin) begin
               w = pack_word(KIND_HEADER, '0, '0, '0, 1'b0, ERR_TRUNCATED);
               close_file(1'b1);
            end else begin
               w = pack_word(KIND_HEADER, '0, '0, '0, 1'b0, ERR_NONE);
               dec_state = RUN_PARSE;
            end
            return 1'b1;
         end
         hdr_count = n + 1;
         if (fin) begin
            w = abort_file(ERR_TRUNCATED, 1'b1);
            return 1'b1;
         end
         return 1'b0;
      end

      // Run bytes: low id, high id when ids are wide, then the count.
      if (id_phase == 0) begin
         run_id   = {8'h00, b};
         id_phase = ids_wide ? 1 : 2;
      end else if (id_phase == 1) begin
         run_id[15:8] = b;
         id_phase     = 2;
      end else begin
         start    = next_cell;
         id_phase = 0;
         if (b > cells_remaining) begin
            w = abort_file(ERR_OVERFLOW, fin);
            return 1'b1;
         end
         next_cell       += 32'(b);
         cells_remaining -= 32'(b);
         if (b != 8'h00 && run_id > top_id) top_id = run_id;
         if (cells_remaining == 0) begin
            w = pack_word(KIND_RUN, run_id, b, start, 1'b1, ERR_NONE);
            close_file(fin);
         end else if (fin) begin
            w = pack_word(KIND_RUN, run_id, b, start, 1'b0, ERR_TRUNCATED);
            close_file(1'b1);
         end else begin
            w = pack_word(KIND_RUN, run_id, b, start, 1'b0, ERR_NONE);
         end
         return 1'b1;
      end
      if (fin) begin
         w = abort_file(ERR_TRUNCATED, 1'b1);
         return 1'b1;
      end
      return 1'b0;
   endfunction

   // ---------------------------------------------------------------- checking

   function automatic string word_text(slice_word_type w);
      return $sformatf("kind %0d id %h len %0d start %0d w %0d h %0d done %b max %h err %0d",
                       w.kind, w.material_id, w.run_length, w.run_start, w.slice_width,
                       w.slice_height, w.slice_done, w.max_material, w.error_code);
   endfunction

   task automatic note_failure(input string what);
      error_total++;
      if (error_total <= MAX_REPORTS) $display("%0t: %s", $time, what);
   endtask

   // Each accepted result word is compared with the oldest expected word.
   always @(posedge clock) begin : result_check
      slice_word_type got, want;
      if (!reset && rsp_valid && !rsp_stall) begin
         got.kind         = kind_type'(rsp_kind);
         got.material_id  = rsp_material_id;
         got.run_length   = rsp_run_length;
         got.run_start    = rsp_run_start;
         got.slice_width  = rsp_slice_width;
         got.slice_height = rsp_slice_height;
         got.slice_done   = rsp_slice_done;
         got.max_material = rsp_max_material;
         got.error_code   = err_type'(rsp_error_code);
         if (expected_words.size() == 0) begin
            note_failure({"unexpected result word: ", word_text(got)});
         end else begin
            want = expected_words.pop_front();
            if (got.kind !== want.kind || got.material_id !== want.material_id ||
                got.run_length !== want.run_length || got.run_start !== want.run_start ||
                got.slice_width !== want.slice_width ||
                got.slice_height !== want.slice_height ||
                got.slice_done !== want.slice_done ||
                got.max_material !== want.max_material ||
                got.error_code !== want.error_code) begin
               note_failure({"mismatch: expected ", word_text(want), " / got ", word_text(got)});
            end
         end
      end
   end

   // Receiver: random stalls, or a solid hold while the pressure test asks for one.
   always @(posedge clock) begin
      rsp_stall <= holding || ($urandom_range(0, 99) < recv_idle_pct);
   end

   // ---------------------------------------------------------------- stimulus

   task automatic set_idle(input int send_pct, input int recv_pct);
      send_idle_pct = send_pct;
      recv_idle_pct = recv_pct;
   endtask

   // Offers one byte, holds it until accepted, then predicts its result.
   task automatic send_byte(input logic [7:0] b, input bit fin);
      slice_word_type w;
      bit counted;
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_stream_byte <= b;
      req_final_byte  <= fin;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      counted = (dec_state != SKIP_TO_END);
      if (decode_byte(b, fin, w)) expected_words.push_back(w);
      if (counted) bytes_decoded++;
   endtask

   // Sends a header, optionally with one byte replaced and a final byte part way through.
   task automatic send_header(input logic [31:0] w, input logic [31:0] h, input logic [31:0] idw,
                              input int fin_at, input int bad_at, input logic [7:0] bad_val);
      logic [7:0] hb [HDR_LEN];
      for (int i = 0; i < MAGIC_LEN; i++) hb[i] = MAGIC[i];
      for (int i = 0; i < 4; i++) begin
         hb[MAGIC_LEN + i]  = w[8*i +: 8];
         hb[WIDTH_END + i]  = h[8*i +: 8];
         hb[HEIGHT_END + i] = idw[8*i +: 8];
      end
      hb[HDR_PAD] = 8'($urandom);
      if (bad_at >= 0) hb[bad_at] = bad_val;
      for (int i = 0; i < HDR_LEN; i++) begin
         send_byte(hb[i], i == fin_at);
         if (i == fin_at) break;
      end
   endtask

   task automatic send_run(input logic [15:0] id, input bit wide, input logic [7:0] count,
                           input int fin_at);
      send_byte(id[7:0], fin_at == FIN_ID_LOW);
      if (fin_at == FIN_ID_LOW) return;
      if (wide) begin
         send_byte(id[15:8], fin_at == FIN_ID_HIGH);
         if (fin_at == FIN_ID_HIGH) return;
      end
      send_byte(count, fin_at == FIN_COUNT);
   endtask

   // After an error or a finished slice, skip a few junk bytes and end with a final byte.
   task automatic finish_file();
      if (dec_state == SKIP_TO_END) begin
         repeat ($urandom_range(0, 2)) send_byte(8'($urandom), 1'b0);
         send_byte(8'($urandom), 1'b1);
      end
   endtask

   task automatic test_bad_magic();
      send_byte(MAGIC[0], 1'b0);
      send_byte(8'h00, 1'b0);
      finish_file();
      // Bad magic on a final byte: the very next byte starts a header.
      send_byte(8'hFF, 1'b1);
      send_byte(MAGIC[0], 1'b0);
      send_byte(MAGIC[1], 1'b0);
      send_byte(MAGIC[2], 1'b0);
      send_byte(8'h58, 1'b1);
   endtask

   task automatic test_header_errors();
      send_header(MAX_SIDE + 1, 1, 32'(ID_WIDTH_NARROW), HDR_NO_FIN, NO_CORRUPT, 8'h00);
      finish_file();
      send_header(1, 32'hFFFF_FFFF, 32'(ID_WIDTH_WIDE), HDR_NO_FIN, NO_CORRUPT, 8'h00);
      finish_file();
      send_header(2, 2, 3, HDR_NO_FIN, NO_CORRUPT, 8'h00);
      finish_file();
      // Upper id-width bytes must be zero too.
      send_header(2, 2, 32'h0000_0101, HDR_NO_FIN, NO_CORRUPT, 8'h00);
      finish_file();
      send_header(2, 2, 0, HDR_NO_FIN, NO_CORRUPT, 8'h00);
      finish_file();
   endtask

   task automatic test_empty_slice();
      send_header(0, MAX_SIDE, 32'(ID_WIDTH_NARROW), HDR_PAD, NO_CORRUPT, 8'h00);
      send_header(MAX_SIDE, 0, 32'(ID_WIDTH_WIDE), HDR_NO_FIN, NO_CORRUPT, 8'h00);
      finish_file();
   endtask

   task automatic test_narrow_runs();
      send_header(3, 2, 32'(ID_WIDTH_NARROW), HDR_NO_FIN, NO_CORRUPT, 8'h00);
      // A zero-length run of a large id must not raise the maximum.
      send_run(16'h00FF, 1'b0, 8'd0, FIN_NONE);
      send_run(16'h0007, 1'b0, 8'd2, FIN_NONE);
      send_run(16'h0080, 1'b0, 8'd4, FIN_COUNT);
   endtask

   task automatic test_wide_runs();
      send_header(MAX_SIDE, MAX_SIDE, 32'(ID_WIDTH_WIDE), HDR_NO_FIN, NO_CORRUPT, 8'h00);
      send_run(16'hFFFF, 1'b1, 8'd255, FIN_NONE);
      send_run(16'h8001, 1'b1, 8'd0, FIN_NONE);
      send_run(16'h0000, 1'b1, 8'd255, FIN_NONE);
      send_run(16'h1234, 1'b1, 8'd1, FIN_ID_HIGH);
      // Count larger than the cells left.
      send_header(1, 1, 32'(ID_WIDTH_WIDE), HDR_NO_FIN, NO_CORRUPT, 8'h00);
      send_run(16'hABCD, 1'b1, 8'd2, FIN_NONE);
      finish_file();
      // A run that leaves cells uncovered on a final byte is reported as truncated.
      send_header(2, 1, 32'(ID_WIDTH_WIDE), HDR_NO_FIN, NO_CORRUPT, 8'h00);
      send_run(16'h5A5A, 1'b1, 8'd1, FIN_COUNT);
   endtask

   task automatic test_truncation();
      send_header(5, 5, 32'(ID_WIDTH_NARROW), MAGIC_LEN + 2, NO_CORRUPT, 8'h00);
      send_header(5, 5, 32'(ID_WIDTH_NARROW), HDR_PAD, NO_CORRUPT, 8'h00);
      send_header(3, 3, 32'(ID_WIDTH_NARROW), HEIGHT_END, NO_CORRUPT, 8'h00);
      // Content errors on a final byte take precedence over truncation.
      send_header(9000, 1, 32'(ID_WIDTH_NARROW), HDR_FIELDS_LEN - 1, NO_CORRUPT, 8'h00);
      send_header(1, 1, 32'(ID_WIDTH_NARROW), HDR_NO_FIN, NO_CORRUPT, 8'h00);
      send_run(16'h0005, 1'b0, 8'd3, FIN_COUNT);
      send_header(4, 4, 32'(ID_WIDTH_NARROW), HDR_NO_FIN, NO_CORRUPT, 8'h00);
      send_run(16'h0009, 1'b0, 8'd1, FIN_ID_LOW);
   endtask

   // The receiver holds off for a long stretch while the sender keeps offering bytes.
   task automatic test_receiver_backpressure();
      logic [7:0] cnt;
      set_idle(0, 0);
      fork
         begin
            holding <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
            holding <= 1'b0;
         end
      join_none
      send_header(16, 16, 32'(ID_WIDTH_NARROW), HDR_NO_FIN, NO_CORRUPT, 8'h00);
      while (dec_state == RUN_PARSE) begin
         cnt = 8'($urandom_range(1, 4));
         if (cnt > cells_remaining) cnt = cells_remaining[7:0];
         send_run(16'($urandom), 1'b0, cnt, (cnt == cells_remaining) ? FIN_COUNT : FIN_NONE);
      end
   endtask

   // One random file: mostly well-formed with small sizes, some broken or oversized.
   task automatic send_random_file();
      logic [31:0] w, h, idw;
      logic [15:0] id;
      logic [7:0]  cnt, bad_val;
      int          r, fin_at, bad_at, runs, cap;
      bit          wide;
      r = $urandom_range(0, 99);
      if (r < 75) begin
         w = $urandom_range(0, 6);
         h = $urandom_range(0, 6);
      end else if (r < 85) begin
         w = $urandom_range(0, 1) ? MAX_SIDE : $urandom_range(1, MAX_SIDE);
         h = $urandom_range(0, 1) ? MAX_SIDE : $urandom_range(1, MAX_SIDE);
      end else if (r < 92) begin
         w = $urandom;
         h = $urandom;
      end else begin
         w = $urandom_range(MAX_SIDE - 1, MAX_SIDE + 1);
         h = $urandom_range(0, 3);
      end
      r = $urandom_range(0, 99);
      if (r < 90)      idw = $urandom_range(ID_WIDTH_NARROW, ID_WIDTH_WIDE);
      else if (r < 95) idw = $urandom_range(0, 3);
      else             idw = $urandom;
      bad_at  = ($urandom_range(0, 99) < 6) ? int'($urandom_range(0, HDR_PAD)) : NO_CORRUPT;
      bad_val = 8'($urandom);
      fin_at  = ($urandom_range(0, 99) < 5) ? int'($urandom_range(0, HDR_PAD)) : HDR_NO_FIN;
      send_header(w, h, idw, fin_at, bad_at, bad_val);

      wide = ids_wide;
      runs = 0;
      while (dec_state == RUN_PARSE) begin
         id  = wide ? 16'($urandom) : 16'($urandom_range(0, 255));
         cap = (cells_remaining > 255) ? 255 : int'(cells_remaining);
         r   = $urandom_range(0, 99);
         if (r < 30)      cnt = 8'(cap);
         else if (r < 35) cnt = 8'd0;
         else if (r < 40) cnt = 8'($urandom_range(0, 255));
         else             cnt = 8'($urandom_range(0, cap));
         fin_at = FIN_NONE;
         // Large slices cannot be covered in a few runs; cut them short.
         if (runs >= MAX_RUNS_PER_FILE) begin
            fin_at = FIN_ID_LOW;
         end else if ($urandom_range(0, 99) < 4) begin
            fin_at = int'($urandom_range(FIN_ID_LOW, FIN_COUNT));
            if (!wide && fin_at == FIN_ID_HIGH) fin_at = FIN_COUNT;
         end else if (cnt == cells_remaining && $urandom_range(0, 1)) begin
            fin_at = FIN_COUNT;
         end
         send_run(id, wide, cnt, fin_at);
         runs++;
      end
      finish_file();
   endtask

   // Random files in three stretches: slow receiver, slow sender, then no idling.
   task automatic test_random_files();
      int goal;
      goal = bytes_decoded + RANDOM_BYTES;
      while (bytes_decoded < goal) begin
         if (bytes_decoded < goal - 2 * RANDOM_BYTES / 3) set_idle(7, 81);
         else if (bytes_decoded < goal - RANDOM_BYTES / 3) set_idle(81, 7);
         else set_idle(0, 0);
         send_random_file();
      end
   endtask

   // ---------------------------------------------------------------- sequence

   initial begin
      int waited;
      dec_state = HDR_PARSE;
      clear_file();
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      set_idle(7, 81);
      test_bad_magic();
      test_header_errors();
      test_empty_slice();
      test_narrow_runs();
      test_wide_runs();
      test_truncation();
      test_receiver_backpressure();
      test_random_files();

      // Let every expected word come out, then watch a little longer for strays.
      req_valid <= 1'b0;
      set_idle(0, 0);
      waited = 0;
      while (expected_words.size() != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (expected_words.size() != 0)
         note_failure($sformatf("%0d expected words never arrived", expected_words.size()));

      if (error_total == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

   // Watchdog, far beyond the slowest correct run.
   initial begin
      #2000000;
      $display("FAIL");
      $finish;
   end

endmodule

FILE: sim.f
+incdir+design
design/slrd_pkg.sv
design/slice_run_length_decoder_top.sv
tb/sv/tb_top.sv
